>>> rtl/clb_pkg.sv
package clb_pkg;

    // Fixed field widths
    localparam int POS_W     = 32;
    localparam int DIFF_W    = 33;
    localparam int PIDX_W    = 16;
    localparam int CID_W     = 12;
    localparam int LINK_W    = 16;
    localparam int GRID_W    = 5;
    localparam int COORD_W   = 5;
    localparam int LIN_W     = 10;
    localparam int ID_W      = 15;
    localparam int CFG_IDX_W = 3;
    localparam int EPOCH_W   = 8;

    // Register reset values
    localparam logic [POS_W-1:0]  INV_RESET  = 32'h0001_0000;
    localparam logic [GRID_W-1:0] GRID_RESET = 5'd10;

    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_INSERT = 2'd1,
        FUNC_READ   = 2'd2
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X = 3'd0,
        CFG_ORIGIN_Y = 3'd1,
        CFG_ORIGIN_Z = 3'd2,
        CFG_INV_CELL = 3'd3,
        CFG_GRID_X   = 3'd4,
        CFG_GRID_Y   = 3'd5,
        CFG_GRID_Z   = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_MUL,
        ST_CHK,
        ST_LIN1,
        ST_LIN2,
        ST_RD,
        ST_WB
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic  load;
        logic  mul_en;
        axis_t axis;
        logic  lin1;
        logic  lin2;
        logic  rd_en;
        logic  sweep_en;
        logic  epoch_inc;
        logic  epoch_init;
        logic  out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic sweep_last;
        logic epoch_full;
        logic out_free;
    } stat_t;

endpackage

>>> rtl/cell_list_binning.sv
// Linked cell list builder. One item is worked at a time; the result sits in an
// output register so the next item can be taken while it waits. An insert runs
// the three axes in turn through the one 32x32 multiplier, then a coordinate
// check, two linearisation steps and a read-modify-write of the single-port head
// table. Clears bump an 8-bit epoch tag held with each head entry; after reset,
// and on every 255th clear, a pass over the MAX_CELLS entries rewrites the whole
// table, during which no beat is accepted (register writes are always taken).
// The receiver keeps the next-link array: an insert returns the cell's previous
// head as the particle's link.
module cell_list_binning #(
    parameter int MAX_CELLS     = 4096,
    parameter int MAX_PARTICLES = 65536
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // register write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [clb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [clb_pkg::POS_W-1:0]        cfg_data,
    // input channel
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       func,
    input  logic [clb_pkg::PIDX_W-1:0]       particle_index,
    input  logic signed [clb_pkg::POS_W-1:0] pos_x,
    input  logic signed [clb_pkg::POS_W-1:0] pos_y,
    input  logic signed [clb_pkg::POS_W-1:0] pos_z,
    input  logic [clb_pkg::CID_W-1:0]        query_cell,
    // output channel
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [clb_pkg::CID_W-1:0]        cell_id,
    output logic                             link_valid,
    output logic [clb_pkg::LINK_W-1:0]       link,
    output logic                             out_of_box
);

    clb_pkg::cmd_t  cmd;
    clb_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    clb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .func     (func),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    clb_datapath #(
        .MAX_CELLS     (MAX_CELLS),
        .MAX_PARTICLES (MAX_PARTICLES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .func           (func),
        .particle_index (particle_index),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pos_z          (pos_z),
        .query_cell     (query_cell),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .cell_id        (cell_id),
        .link_valid     (link_valid),
        .link           (link),
        .out_of_box     (out_of_box),
        .cmd            (cmd),
        .stat           (stat)
    );

    // One item in flight: an accepted beat closes the input side
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while an item is in flight");

    // Table pass runs straight after reset
    a_sweep_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !in_ready)
        else $error("input open before the table pass");

    // Rejected insert stores and reports nothing else
    a_oob_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_box |-> cell_id == '0 && !link_valid && link == '0)
        else $error("out-of-box result carries data");

    // End of list reads as zero
    a_empty_link: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !link_valid |-> link == '0)
        else $error("empty list with non-zero link");

endmodule

>>> rtl/clb_ctrl.sv
module clb_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [1:0]     func,
    output logic           in_ready,
    output clb_pkg::cmd_t  cmd,
    input  clb_pkg::stat_t stat
);

    clb_pkg::state_t state_reg, state_next;
    clb_pkg::axis_t  axis_reg, axis_next;
    logic            clr_reg, clr_next;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= clb_pkg::ST_SWEEP;
            axis_reg  <= clb_pkg::AXIS_X;
            clr_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            clr_reg   <= clr_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        clr_next   = clr_reg;
        unique case (state_reg)
            clb_pkg::ST_SWEEP:
            begin
                if (stat.sweep_last)
                begin
                    state_next = clr_reg ? clb_pkg::ST_WB : clb_pkg::ST_IDLE;
                    clr_next   = 1'b0;
                end
            end
            clb_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (func)
                        clb_pkg::FUNC_CLEAR:
                        begin
                            if (stat.epoch_full)
                            begin
                                state_next = clb_pkg::ST_SWEEP;
                                clr_next   = 1'b1;
                            end
                            else
                            begin
                                state_next = clb_pkg::ST_WB;
                            end
                        end
                        clb_pkg::FUNC_INSERT:
                        begin
                            state_next = clb_pkg::ST_MUL;
                            axis_next  = clb_pkg::AXIS_X;
                        end
                        clb_pkg::FUNC_READ:
                        begin
                            state_next = clb_pkg::ST_RD;
                        end
                        default:
                        begin
                            state_next = clb_pkg::ST_WB;
                        end
                    endcase
                end
            end
            clb_pkg::ST_MUL:
            begin
                if (axis_reg == clb_pkg::AXIS_Z)
                begin
                    state_next = clb_pkg::ST_CHK;
                end
                else if (axis_reg == clb_pkg::AXIS_X)
                begin
                    axis_next = clb_pkg::AXIS_Y;
                end
                else
                begin
                    axis_next = clb_pkg::AXIS_Z;
                end
            end
            clb_pkg::ST_CHK:  state_next = clb_pkg::ST_LIN1;
            clb_pkg::ST_LIN1: state_next = clb_pkg::ST_LIN2;
            clb_pkg::ST_LIN2: state_next = clb_pkg::ST_RD;
            clb_pkg::ST_RD:   state_next = clb_pkg::ST_WB;
            clb_pkg::ST_WB:
            begin
                if (stat.out_free)
                begin
                    state_next = clb_pkg::ST_IDLE;
                end
            end
        endcase
    end

    // Commands
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            clb_pkg::ST_SWEEP:
            begin
                cmd.sweep_en   = 1'b1;
                cmd.epoch_init = stat.sweep_last;
            end
            clb_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load      = 1'b1;
                    cmd.epoch_inc = (func == clb_pkg::FUNC_CLEAR) && !stat.epoch_full;
                end
            end
            clb_pkg::ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                cmd.axis   = axis_reg;
            end
            clb_pkg::ST_CHK:  cmd = '0;
            clb_pkg::ST_LIN1: cmd.lin1 = 1'b1;
            clb_pkg::ST_LIN2: cmd.lin2 = 1'b1;
            clb_pkg::ST_RD:   cmd.rd_en = 1'b1;
            clb_pkg::ST_WB:   cmd.out_load = stat.out_free;
        endcase
    end

endmodule

>>> rtl/clb_datapath.sv
module clb_datapath #(
    parameter int MAX_CELLS     = 4096,
    parameter int MAX_PARTICLES = 65536
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // register writes
    input  logic                                cfg_we,
    input  logic [clb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [clb_pkg::POS_W-1:0]           cfg_data,
    // input beat
    input  logic [1:0]                          func,
    input  logic [clb_pkg::PIDX_W-1:0]          particle_index,
    input  logic signed [clb_pkg::POS_W-1:0]    pos_x,
    input  logic signed [clb_pkg::POS_W-1:0]    pos_y,
    input  logic signed [clb_pkg::POS_W-1:0]    pos_z,
    input  logic [clb_pkg::CID_W-1:0]           query_cell,
    // result beat
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [clb_pkg::CID_W-1:0]           cell_id,
    output logic                                link_valid,
    output logic [clb_pkg::LINK_W-1:0]          link,
    output logic                                out_of_box,
    // control
    input  clb_pkg::cmd_t                       cmd,
    output clb_pkg::stat_t                      stat
);

    localparam int CELL_AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int HEAD_W  = (MAX_PARTICLES >= 65536) ? 16 : $clog2(MAX_PARTICLES);
    localparam int WORD_W  = clb_pkg::EPOCH_W + HEAD_W;

    // Configuration registers
    logic signed [clb_pkg::POS_W-1:0] origin_x_reg, origin_y_reg, origin_z_reg;
    logic [clb_pkg::POS_W-1:0]        inv_reg;
    logic [clb_pkg::GRID_W-1:0]       grid_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            origin_z_reg <= '0;
            inv_reg      <= clb_pkg::INV_RESET;
            grid_reg[0]  <= clb_pkg::GRID_RESET;
            grid_reg[1]  <= clb_pkg::GRID_RESET;
            grid_reg[2]  <= clb_pkg::GRID_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                clb_pkg::CFG_ORIGIN_X: origin_x_reg <= cfg_data;
                clb_pkg::CFG_ORIGIN_Y: origin_y_reg <= cfg_data;
                clb_pkg::CFG_ORIGIN_Z: origin_z_reg <= cfg_data;
                clb_pkg::CFG_INV_CELL: inv_reg      <= cfg_data;
                clb_pkg::CFG_GRID_X:   grid_reg[0]  <= cfg_data[clb_pkg::GRID_W-1:0];
                clb_pkg::CFG_GRID_Y:   grid_reg[1]  <= cfg_data[clb_pkg::GRID_W-1:0];
                clb_pkg::CFG_GRID_Z:   grid_reg[2]  <= cfg_data[clb_pkg::GRID_W-1:0];
                default:               origin_x_reg <= origin_x_reg;
            endcase
        end
    end

    // Captured input beat; origin subtracted on the way in
    logic [1:0]                        func_reg;
    logic [clb_pkg::PIDX_W-1:0]        pidx_reg;
    logic [clb_pkg::CID_W-1:0]         query_reg;
    logic                              q_ok_reg;
    logic signed [clb_pkg::DIFF_W-1:0] diff_reg [3];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg    <= func;
            pidx_reg    <= particle_index;
            query_reg   <= query_cell;
            q_ok_reg    <= 32'(query_cell) < 32'(MAX_CELLS);
            diff_reg[0] <= clb_pkg::DIFF_W'(pos_x) - clb_pkg::DIFF_W'(origin_x_reg);
            diff_reg[1] <= clb_pkg::DIFF_W'(pos_y) - clb_pkg::DIFF_W'(origin_y_reg);
            diff_reg[2] <= clb_pkg::DIFF_W'(pos_z) - clb_pkg::DIFF_W'(origin_z_reg);
        end
    end

    // Shared multiplier, one axis a cycle
    logic signed [clb_pkg::DIFF_W-1:0] mul_diff;
    logic [2*clb_pkg::POS_W-1:0]       prod_reg;
    logic                              prod_neg_reg;
    clb_pkg::axis_t                    prod_axis_reg;
    logic                              prod_vld_reg;

    assign mul_diff = diff_reg[cmd.axis];

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg      <= mul_diff[clb_pkg::POS_W-1:0] * inv_reg;
            prod_neg_reg  <= mul_diff[clb_pkg::DIFF_W-1];
            prod_axis_reg <= cmd.axis;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= cmd.mul_en;
        end
    end

    // Floor and range check of one coordinate
    logic [clb_pkg::POS_W-1:0]   c_eff;
    logic [clb_pkg::GRID_W-1:0]  grid_sel;
    logic                        axis_bad;
    logic                        bad_reg;
    logic [clb_pkg::COORD_W-1:0] coord_reg [3];

    assign c_eff    = prod_neg_reg ? '0 : prod_reg[2*clb_pkg::POS_W-1:clb_pkg::POS_W];
    assign grid_sel = grid_reg[prod_axis_reg];
    assign axis_bad = (prod_neg_reg && (inv_reg != '0))
                   || (c_eff[clb_pkg::POS_W-1:clb_pkg::COORD_W] != '0)
                   || (c_eff[clb_pkg::COORD_W-1:0] >= grid_sel);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bad_reg <= 1'b0;
        end
        else if (prod_vld_reg)
        begin
            bad_reg                  <= bad_reg | axis_bad;
            coord_reg[prod_axis_reg] <= c_eff[clb_pkg::COORD_W-1:0];
        end
    end

    // Linearise: id = x + gx * (y + gy * z)
    logic [clb_pkg::LIN_W-1:0] lin_prod, lin_reg;
    logic [clb_pkg::ID_W-1:0]  id_sum, id_reg;
    logic                      oob_reg;

    assign lin_prod = clb_pkg::LIN_W'(grid_reg[1]) * clb_pkg::LIN_W'(coord_reg[2]);
    assign id_sum   = clb_pkg::ID_W'(grid_reg[0]) * clb_pkg::ID_W'(lin_reg)
                    + clb_pkg::ID_W'(coord_reg[0]);

    always_ff @(posedge clk)
    begin
        if (cmd.lin1)
        begin
            lin_reg <= lin_prod + clb_pkg::LIN_W'(coord_reg[1]);
        end
        if (cmd.lin2)
        begin
            id_reg  <= id_sum;
            oob_reg <= bad_reg
                    || (32'(id_sum) >= 32'(MAX_CELLS))
                    || (32'(pidx_reg) >= 32'(MAX_PARTICLES));
        end
    end

    // Clear epoch and sweep counter
    logic [clb_pkg::EPOCH_W-1:0] epoch_reg;
    logic [CELL_AW-1:0]          sweep_cnt_reg;
    logic                        sweep_last;

    assign sweep_last = sweep_cnt_reg == CELL_AW'(MAX_CELLS - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epoch_reg     <= clb_pkg::EPOCH_W'(1);
            sweep_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.epoch_init)
            begin
                epoch_reg <= clb_pkg::EPOCH_W'(1);
            end
            else if (cmd.epoch_inc)
            begin
                epoch_reg <= epoch_reg + 1'b1;
            end
            if (cmd.sweep_en)
            begin
                sweep_cnt_reg <= sweep_last ? '0 : sweep_cnt_reg + 1'b1;
            end
        end
    end

    // Head table: {epoch tag, head}; an entry is present when its tag is current
    logic [WORD_W-1:0]  head_mem [MAX_CELLS];
    logic [WORD_W-1:0]  rd_data_reg;
    logic [CELL_AW-1:0] tab_addr;
    logic [CELL_AW-1:0] wr_addr;
    logic [WORD_W-1:0]  wr_data;
    logic               is_insert;
    logic               wr_en;

    assign is_insert = func_reg == clb_pkg::FUNC_INSERT;
    assign tab_addr  = is_insert ? CELL_AW'(id_reg) : CELL_AW'(query_reg);
    assign wr_en     = cmd.sweep_en || (cmd.out_load && is_insert && !oob_reg);
    assign wr_addr   = cmd.sweep_en ? sweep_cnt_reg : tab_addr;
    assign wr_data   = cmd.sweep_en ? '0 : {epoch_reg, HEAD_W'(pidx_reg)};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            head_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_data_reg <= head_mem[tab_addr];
        end
    end

    // Result formation
    logic                       present;
    logic [clb_pkg::LINK_W-1:0] head_ext;
    logic [clb_pkg::CID_W-1:0]  res_cid;
    logic                       res_lv;
    logic [clb_pkg::LINK_W-1:0] res_link;
    logic                       res_oob;

    assign present  = rd_data_reg[WORD_W-1:HEAD_W] == epoch_reg;
    assign head_ext = clb_pkg::LINK_W'(rd_data_reg[HEAD_W-1:0]);

    always_comb
    begin
        res_cid  = '0;
        res_lv   = 1'b0;
        res_link = '0;
        res_oob  = 1'b0;
        unique case (func_reg)
            clb_pkg::FUNC_INSERT:
            begin
                if (oob_reg)
                begin
                    res_oob = 1'b1;
                end
                else
                begin
                    res_cid  = clb_pkg::CID_W'(id_reg);
                    res_lv   = present;
                    res_link = present ? head_ext : '0;
                end
            end
            clb_pkg::FUNC_READ:
            begin
                res_cid  = query_reg;
                res_lv   = q_ok_reg && present;
                res_link = (q_ok_reg && present) ? head_ext : '0;
            end
            default:
            begin
                res_cid = '0;
            end
        endcase
    end

    // Output register
    logic                       out_valid_reg;
    logic [clb_pkg::CID_W-1:0]  cid_reg;
    logic                       lv_reg;
    logic [clb_pkg::LINK_W-1:0] link_reg;
    logic                       oobo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            cid_reg  <= res_cid;
            lv_reg   <= res_lv;
            link_reg <= res_link;
            oobo_reg <= res_oob;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cell_id    = cid_reg;
    assign link_valid = lv_reg;
    assign link       = link_reg;
    assign out_of_box = oobo_reg;

    assign stat.sweep_last = sweep_last;
    assign stat.epoch_full = &epoch_reg;
    assign stat.out_free   = !out_valid_reg || out_ready;

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import clb_pkg::*;

    localparam int          CELLS       = 4096;
    localparam logic [1:0]  FUNC_UNUSED = 2'd3;
    localparam int          HOLD_CYCLES = 400;

    // One input beat and one result beat
    typedef struct packed {
        logic [1:0]        func;
        logic [PIDX_W-1:0] pidx;
        logic [POS_W-1:0]  px;
        logic [POS_W-1:0]  py;
        logic [POS_W-1:0]  pz;
        logic [CID_W-1:0]  qcell;
    } bin_item_t;

    typedef struct packed {
        logic [CID_W-1:0]  cid;
        logic              lvalid;
        logic [LINK_W-1:0] lnk;
        logic              oob;
    } bin_res_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [POS_W-1:0]        cfg_data  = '0;
    logic                    in_valid  = 1'b0;
    logic                    in_ready;
    logic [1:0]              func      = '0;
    logic [PIDX_W-1:0]       particle_index = '0;
    logic signed [POS_W-1:0] pos_x     = '0;
    logic signed [POS_W-1:0] pos_y     = '0;
    logic signed [POS_W-1:0] pos_z     = '0;
    logic [CID_W-1:0]        query_cell = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [CID_W-1:0]        cell_id;
    logic                    link_valid;
    logic [LINK_W-1:0]       link;
    logic                    out_of_box;

    cell_list_binning u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .particle_index (particle_index),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pos_z          (pos_z),
        .query_cell     (query_cell),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .cell_id        (cell_id),
        .link_valid     (link_valid),
        .link           (link),
        .out_of_box     (out_of_box)
    );

    always #5 clk = ~clk;

    // Shadow of the box registers, reset values
    logic [POS_W-1:0]  box_org_x = '0;
    logic [POS_W-1:0]  box_org_y = '0;
    logic [POS_W-1:0]  box_org_z = '0;
    logic [POS_W-1:0]  box_inv   = INV_RESET;
    logic [GRID_W-1:0] box_gx    = GRID_RESET;
    logic [GRID_W-1:0] box_gy    = GRID_RESET;
    logic [GRID_W-1:0] box_gz    = GRID_RESET;

    // Shadow of the head table
    logic [PIDX_W-1:0] head_pid  [CELLS];
    bit                head_live [CELLS];

    bin_item_t queued_items[$];
    bin_res_t  awaited_results[$];
    bin_item_t offer;

    int  tx_gap      = 0;
    int  rx_stall    = 0;
    bit  tx_idle_en  = 1'b1;
    bit  rx_idle_en  = 1'b1;
    int  n_accepted  = 0;
    int  n_checked   = 0;
    int  n_errors    = 0;
    int  hold_at     = -1;
    bit  hold_done   = 1'b0;
    int  hold_left   = 0;
    int  n_ins       = 0;
    int  n_oob       = 0;
    int  n_rd        = 0;
    int  n_rd_hit    = 0;
    int  n_clr       = 0;
    int  n_boxes     = 0;

    // Cell coordinate along one axis; 0 when it falls outside 0..g-1
    function automatic bit axis_cell(input logic [POS_W-1:0] p, input logic [POS_W-1:0] o,
                                     input logic [GRID_W-1:0] g, output logic [63:0] c);
        longint      d;
        logic [63:0] prod;
        d = longint'(signed'(p)) - longint'(signed'(o));
        c = '0;
        if (d < 0)
        begin
            if (box_inv != 0)
                return 1'b0;
        end
        else
        begin
            prod = d;
            prod = prod * {32'd0, box_inv};
            c = prod >> 32;
        end
        return c < {59'd0, g};
    endfunction

    // Apply one beat to the shadow table and return its result
    function automatic bin_res_t list_update(input bin_item_t it);
        bin_res_t    r;
        logic [63:0] cx, cy, cz, id;
        bit          ok;
        r = '0;
        case (it.func)
            FUNC_CLEAR: head_live = '{default: 1'b0};
            FUNC_INSERT:
            begin
                ok = axis_cell(it.px, box_org_x, box_gx, cx);
                ok = axis_cell(it.py, box_org_y, box_gy, cy) && ok;
                ok = axis_cell(it.pz, box_org_z, box_gz, cz) && ok;
                id = cx + cy * box_gx + cz * box_gx * box_gy;
                if (!ok || id >= CELLS)
                    r.oob = 1'b1;
                else
                begin
                    r.cid = id[CID_W-1:0];
                    if (head_live[id])
                    begin
                        r.lvalid = 1'b1;
                        r.lnk    = head_pid[id];
                    end
                    head_pid[id]  = it.pidx;
                    head_live[id] = 1'b1;
                end
            end
            FUNC_READ:
            begin
                r.cid = it.qcell;
                if (head_live[it.qcell])
                begin
                    r.lvalid = 1'b1;
                    r.lnk    = head_pid[it.qcell];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic bin_item_t mk(input logic [1:0] f, input logic [PIDX_W-1:0] p,
                                     input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                                     input logic [POS_W-1:0] z, input logic [CID_W-1:0] q);
        bin_item_t it;
        it.func  = f;
        it.pidx  = p;
        it.px    = x;
        it.py    = y;
        it.pz    = z;
        it.qcell = q;
        return it;
    endfunction

    // Position whose cell along this axis is mostly inside the grid, now and then just past it
    function automatic logic [POS_W-1:0] aim_axis(input logic [POS_W-1:0] o,
                                                  input logic [GRID_W-1:0] g);
        logic [63:0] c, lo, hi, span;
        if (box_inv == 0)
            return o + $urandom;
        if (g == 0 || $urandom_range(0, 15) == 0)
            c = g;
        else
            c = $urandom_range(0, g - 1);
        lo   = ((c << 32) + box_inv - 1) / box_inv;
        hi   = (((c + 1) << 32) + box_inv - 1) / box_inv - 1;
        span = hi - lo + 1;
        return o + POS_W'(lo + ({$urandom, $urandom} % span));
    endfunction

    function automatic bin_item_t rand_item();
        bin_item_t   it;
        int          roll;
        int unsigned ncell;
        it = mk(FUNC_INSERT, $urandom, $urandom, $urandom, $urandom, $urandom);
        roll  = $urandom_range(0, 99);
        ncell = box_gx * box_gy * box_gz;
        if (roll < 3)
            it.func = FUNC_CLEAR;
        else if (roll < 5)
            it.func = FUNC_UNUSED;
        else if (roll < 35)
        begin
            it.func = FUNC_READ;
            if (roll < 31 && ncell != 0 && ncell <= CELLS)
                it.qcell = $urandom_range(0, ncell - 1);
        end
        else if (roll >= 42)
        begin
            it.px = aim_axis(box_org_x, box_gx);
            it.py = aim_axis(box_org_y, box_gy);
            it.pz = aim_axis(box_org_z, box_gz);
        end
        if ($urandom_range(0, 15) == 0)
            it.pidx = $urandom_range(0, 1) ? '1 : '0;
        return it;
    endfunction

    // Register write beat, only issued while the block is idle
    task automatic write_reg(input cfg_idx_t idx, input logic [POS_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_ORIGIN_X: box_org_x = val;
            CFG_ORIGIN_Y: box_org_y = val;
            CFG_ORIGIN_Z: box_org_z = val;
            CFG_INV_CELL: box_inv   = val;
            CFG_GRID_X:   box_gx    = val[GRID_W-1:0];
            CFG_GRID_Y:   box_gy    = val[GRID_W-1:0];
            CFG_GRID_Z:   box_gz    = val[GRID_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_box(input logic [POS_W-1:0] ox, input logic [POS_W-1:0] oy,
                           input logic [POS_W-1:0] oz, input logic [POS_W-1:0] inv,
                           input int gx, input int gy, input int gz);
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_ORIGIN_Z, oz);
        write_reg(CFG_INV_CELL, inv);
        write_reg(CFG_GRID_X, gx);
        write_reg(CFG_GRID_Y, gy);
        write_reg(CFG_GRID_Z, gz);
        n_boxes++;
    endtask

    // Wait until nothing is queued, offered or outstanding
    task automatic drain();
        @(negedge clk);
        while (queued_items.size() != 0 || in_valid || awaited_results.size() != 0)
            @(negedge clk);
    endtask

    // Sender: takes beats from the queue, predicts on acceptance
    always @(posedge clk)
    begin : sender
        logic     vld;
        bin_res_t r;
        if (rst_n)
        begin
            vld = in_valid;
            if (in_valid && in_ready)
            begin
                r = list_update(offer);
                awaited_results.push_back(r);
                n_accepted <= n_accepted + 1;
                case (offer.func)
                    FUNC_CLEAR:  n_clr++;
                    FUNC_INSERT:
                    begin
                        n_ins++;
                        n_oob += r.oob;
                    end
                    FUNC_READ:
                    begin
                        n_rd++;
                        n_rd_hit += r.lvalid;
                    end
                    default: ;
                endcase
                vld = 1'b0;
                if (tx_idle_en && $urandom_range(0, 5) == 0)
                    tx_gap = $urandom_range(1, 10);
            end
            if (!vld)
            begin
                if (tx_gap != 0)
                    tx_gap--;
                else if (queued_items.size() != 0)
                begin
                    offer = queued_items.pop_front();
                    vld   = 1'b1;
                end
            end
            in_valid       <= vld;
            func           <= offer.func;
            particle_index <= offer.pidx;
            pos_x          <= offer.px;
            pos_y          <= offer.py;
            pos_z          <= offer.pz;
            query_cell     <= offer.qcell;
        end
    end

    // Long receiver hold-off, so the block backs up into its input
    always @(posedge clk)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (!hold_done && n_accepted == hold_at)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Receiver: checks each result beat against the oldest prediction
    always @(posedge clk)
    begin : receiver
        bin_res_t want;
        logic     rdy;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                n_checked++;
                if (awaited_results.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("[%0t] result beat with nothing expected: cell %0d", $realtime,
                                 cell_id);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (cell_id !== want.cid || link_valid !== want.lvalid
                        || link !== want.lnk || out_of_box !== want.oob)
                    begin
                        n_errors++;
                        if (n_errors <= 10)
                        begin
                            $display("[%0t] beat %0d mismatch: exp cell %0d lv %0b link %0d oob %0b",
                                     $realtime, n_checked, want.cid, want.lvalid, want.lnk,
                                     want.oob);
                            $display("    got cell %0d lv %0b link %0d oob %0b",
                                     cell_id, link_valid, link, out_of_box);
                        end
                    end
                end
            end
            if (hold_left != 0)
                rdy = 1'b0;
            else if (rx_stall != 0)
            begin
                rx_stall--;
                rdy = 1'b0;
            end
            else
            begin
                rdy = 1'b1;
                if (rx_idle_en && $urandom_range(0, 7) == 0)
                    rx_stall = $urandom_range(1, 10);
            end
            out_ready <= rdy;
        end
    end

    // Stimulus
    initial
    begin
        int ph;
        int n;
        head_live = '{default: 1'b0};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: default box, origin 0, unit cells, 10x10x10
        @(negedge clk);
        queued_items.push_back(mk(FUNC_READ, $urandom, $urandom, $urandom, $urandom, 0));
        queued_items.push_back(mk(FUNC_READ, $urandom, $urandom, $urandom, $urandom, 12'hFFF));
        queued_items.push_back(mk(FUNC_INSERT, 16'h0000, 0, 0, 0, $urandom));
        queued_items.push_back(mk(FUNC_INSERT, 16'hFFFF, 32'h0000_8000, 0, 0, $urandom));
        queued_items.push_back(mk(FUNC_READ, $urandom, $urandom, $urandom, $urandom, 0));
        queued_items.push_back(mk(FUNC_INSERT, 7, 32'h0009_FFFF, 32'h0009_FFFF, 32'h0009_FFFF,
                                  $urandom));
        // just past the top of x, then just below zero
        queued_items.push_back(mk(FUNC_INSERT, 8, 32'h000A_0000, 0, 0, $urandom));
        queued_items.push_back(mk(FUNC_INSERT, 9, 32'hFFFF_FFFF, 0, 0, $urandom));
        queued_items.push_back(mk(FUNC_INSERT, 10, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                  $urandom));
        queued_items.push_back(mk(FUNC_INSERT, 11, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                  $urandom));
        queued_items.push_back(mk(FUNC_INSERT, 1, 32'h0001_8000, 32'h0002_0000, 32'h0003_4000,
                                  $urandom));
        queued_items.push_back(mk(FUNC_INSERT, 2, 32'h0001_0001, 32'h0002_FFFF, 32'h0003_0000,
                                  $urandom));
        queued_items.push_back(mk(FUNC_READ, $urandom, $urandom, $urandom, $urandom, 321));
        queued_items.push_back(mk(FUNC_UNUSED, $urandom, $urandom, $urandom, $urandom,
                                  $urandom));
        queued_items.push_back(mk(FUNC_READ, $urandom, $urandom, $urandom, $urandom, 999));
        queued_items.push_back(mk(FUNC_CLEAR, $urandom, $urandom, $urandom, $urandom,
                                  $urandom));
        queued_items.push_back(mk(FUNC_READ, $urandom, $urandom, $urandom, $urandom, 0));
        queued_items.push_back(mk(FUNC_READ, $urandom, $urandom, $urandom, $urandom, 321));
        queued_items.push_back(mk(FUNC_INSERT, 3, 32'h0001_C000, 32'h0002_8000, 32'h0003_0000,
                                  $urandom));
        queued_items.push_back(mk(FUNC_INSERT, 4, 0, 32'h000A_0000, 0, $urandom));
        queued_items.push_back(mk(FUNC_INSERT, 5, 0, 0, 32'hFFFF_0000, $urandom));
        queued_items.push_back(mk(FUNC_READ, $urandom, $urandom, $urandom, $urandom, 321));
        queued_items.push_back(mk(FUNC_CLEAR, $urandom, $urandom, $urandom, $urandom,
                                  $urandom));
        drain();

        // zero reciprocal: every axis lands in cell 0, even below the origin
        set_box(32'h0001_0000, 0, 0, 0, 2, 3, 1);
        @(negedge clk);
        queued_items.push_back(mk(FUNC_INSERT, 20, 32'hFFFB_0000, 32'h0064_0000, 7, $urandom));
        queued_items.push_back(mk(FUNC_INSERT, 21, 32'h7FFF_FFFF, 32'h8000_0000, 0, $urandom));
        queued_items.push_back(mk(FUNC_READ, $urandom, $urandom, $urandom, $urandom, 0));
        drain();
        // zero-sized grid along x: nothing fits
        write_reg(CFG_GRID_X, 0);
        @(negedge clk);
        queued_items.push_back(mk(FUNC_INSERT, 22, 0, 0, 0, $urandom));
        queued_items.push_back(mk(FUNC_READ, $urandom, $urandom, $urandom, $urandom, 0));
        drain();
        // oversized grid: linear id can run past the table
        set_box(0, 0, 0, 32'h0001_0000, 31, 31, 31);
        @(negedge clk);
        queued_items.push_back(mk(FUNC_INSERT, 23, 32'h001E_0000, 32'h001E_0000, 32'h001E_0000,
                                  $urandom));
        queued_items.push_back(mk(FUNC_INSERT, 24, 32'h0005_0000, 32'h0005_0000, 32'h0004_0000,
                                  $urandom));
        queued_items.push_back(mk(FUNC_INSERT, 25, 32'h0005_8000, 32'h0005_8000, 32'h0004_8000,
                                  $urandom));
        queued_items.push_back(mk(FUNC_READ, $urandom, $urandom, $urandom, $urandom, 4004));
        drain();

        // random phases over a spread of box settings
        for (ph = 0; ph < 10; ph++)
        begin
            if (ph == 0)
                set_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 1, 1, 1);
            else if (ph == 1)
                set_box(32'h7FFF_FFF0, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16, 16, 16);
            else if (ph == 9)
                set_box($urandom, $urandom, $urandom, 32'h0001_0000, 16, 16, 16);
            else
                set_box($urandom, $urandom, $urandom,
                        $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1 << 13, 1 << 20),
                        $urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 16));
            @(negedge clk);
            // last phase runs flat out on both sides
            tx_idle_en = (ph != 9) && (ph % 4 != 3);
            rx_idle_en = (ph != 9) && (ph % 3 != 2);
            if (ph == 2)
                hold_at = n_accepted + 20;
            if (ph == 5)
            begin
                // clear-heavy stretch: wraps the clear tag and forces a table rewrite
                for (n = 0; n < 300; n++)
                    queued_items.push_back($urandom_range(0, 9) != 0
                        ? mk(FUNC_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom)
                        : rand_item());
            end
            else
            begin
                for (n = 0; n < 180; n++)
                    queued_items.push_back(rand_item());
            end
            drain();
        end

        repeat (20) @(negedge clk);
        $display("Covered %0d inserts (%0d out of box), %0d reads (%0d non-empty), %0d clears,",
                 n_ins, n_oob, n_rd, n_rd_hit, n_clr);
        $display("over %0d box settings, with %0d result beats checked.", n_boxes, n_checked);
        if (n_errors == 0 && awaited_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Overall time limit
    initial
    begin
        #3000000;
        $display("Timed out with %0d results outstanding", awaited_results.size());
        $display("FAILURE");
        $finish;
    end

endmodule
